// ----- rtl/core/kmc_pkg.sv -----
// Shared types and constants of the k-means cluster engine.
package kmc_pkg;

  // Fixed field widths of the channels.
  localparam int IDX_W      = 12;
  localparam int CRD_W      = 10;
  localparam int LBL_W      = 8;
  localparam int PASS_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Item actions; codes five to seven are ignored.
  typedef enum logic [2:0] {
    ACT_WR_POINT = 3'd0,
    ACT_WR_CENT  = 3'd1,
    ACT_RUN      = 3'd2,
    ACT_RD_CENT  = 3'd3,
    ACT_RD_LABEL = 3'd4
  } action_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 8'd3;

  // Configuration reset values.
  localparam logic [12:0] RST_POINT_COUNT   = 13'd4096;
  localparam logic [7:0]  RST_CLUSTER_COUNT = 8'd128;
  localparam logic [7:0]  RST_MAX_ITER      = 8'd30;
  localparam logic [16:0] RST_THRESHOLD     = 17'd655;

endpackage

// ----- rtl/core/kmc_if.sv -----
// Channel interfaces of the k-means cluster engine.
interface kmc_in_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   action;
  logic [kmc_pkg::IDX_W-1:0]    item_index;
  logic [kmc_pkg::CRD_W-1:0]    coord_x;
  logic [kmc_pkg::CRD_W-1:0]    coord_y;
  logic [kmc_pkg::CRD_W-1:0]    coord_z;
  modport source (output valid, action, item_index, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, action, item_index, coord_x, coord_y, coord_z, output ready);
endinterface

interface kmc_out_if;
  logic                         valid;
  logic                         ready;
  logic [kmc_pkg::CRD_W-1:0]    out_x;
  logic [kmc_pkg::CRD_W-1:0]    out_y;
  logic [kmc_pkg::CRD_W-1:0]    out_z;
  logic [kmc_pkg::LBL_W-1:0]    point_label;
  logic [kmc_pkg::PASS_W-1:0]   passes_done;
  logic                         converged;
  logic                         status;
  modport source (output valid, out_x, out_y, out_z, point_label, passes_done, converged,
                  status, input ready);
  modport sink   (input valid, out_x, out_y, out_z, point_label, passes_done, converged,
                  status, output ready);
endinterface

interface kmc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [kmc_pkg::CFG_IDX_W-1:0]   index;
  logic [kmc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/kmeans_3d_cluster_engine_unit.sv -----
// Load, read and run items: write and ignored items load the result register directly, reads
// go through a memory read first. A run clears the per-cluster sums, scans every centroid for
// each point, then updates each cluster through the divider; an empty one is set to zero.
// One item is taken at a time; a new one is accepted when idle and the result register frees.
// After reset a clearing pass over max(POINTS, CLUSTERS) addresses zeroes the label and
// centroid memories; no item is accepted then, configuration writes are taken.
module kmeans_3d_cluster_engine_unit #(
  parameter int POINTS     = 4096,
  parameter int CLUSTERS   = 128,
  parameter int COORD_BITS = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  kmc_in_if.sink        in_ch,
  kmc_out_if.source     out_ch,
  kmc_cfg_if.sink       cfg_ch
);
  import kmc_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int PW    = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int NPW   = $clog2(POINTS + 1);
  localparam int CAW   = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int NCW   = $clog2(CLUSTERS + 1);
  localparam int LW    = NCW;
  localparam int SW    = CW + NPW;
  localparam int ACCW  = 3 * SW + NPW;
  localparam int DW    = 2 * CW + 2;
  localparam int PRW   = NPW + 17;
  localparam int CLRN  = (POINTS > CLUSTERS) ? POINTS : CLUSTERS;
  localparam int CLRW  = $clog2(CLRN + 1);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_RD, ST_CLR, ST_PT, ST_SCAN, ST_ACC_RD, ST_ACC_WR,
    ST_CHK, ST_U_RD, ST_U_CHK, ST_U_DIV, ST_U_WR
  } state_t;

  // Configuration registers.
  logic [12:0] pc_r;
  logic [7:0]  ncfg_r;
  logic [7:0]  mi_r;
  logic [16:0] thr_r;

  // Sequencer registers.
  state_t          state_r, state_nxt;
  logic [CLRW-1:0] clr_r, clr_nxt;
  logic [NPW-1:0]  pj_r, pj_nxt;
  logic [NCW-1:0]  kiss_r, kiss_nxt;
  logic            v1_r, v1_nxt, v2_r, v2_nxt;
  logic [CAW-1:0]  k1_r, k1_nxt, k2_r, k2_nxt;
  logic [2*CW-1:0] sqx_r, sqx_nxt, sqy_r, sqy_nxt, sqz_r, sqz_nxt;
  logic [CAW-1:0]  best_r, best_nxt;
  logic [DW-1:0]   bestd_r, bestd_nxt;
  logic [NPW-1:0]  chg_r, chg_nxt;
  logic [7:0]      passes_r, passes_nxt;
  logic [1:0]      axis_r, axis_nxt;
  logic [CW-1:0]   qx_r, qx_nxt, qy_r, qy_nxt, qz_r, qz_nxt;
  logic            rdk_r, rdk_nxt;

  // Result register.
  logic            ov_r, ov_nxt;
  logic [CRD_W-1:0]  ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic [LBL_W-1:0]  olab_r, olab_nxt;
  logic [PASS_W-1:0] opass_r, opass_nxt;
  logic            oconv_r, oconv_nxt, ost_r, ost_nxt;

  // Memory ports.
  logic            pt_we, pt_re;
  logic [PW-1:0]   pt_waddr, pt_raddr;
  logic [3*CW-1:0] pt_wdata, pt_rdata;
  logic            lab_we, lab_re;
  logic [PW-1:0]   lab_waddr, lab_raddr;
  logic [LW-1:0]   lab_wdata, lab_rdata;
  logic            cen_we, cen_re;
  logic [CAW-1:0]  cen_waddr, cen_raddr;
  logic [3*CW-1:0] cen_wdata, cen_rdata;
  logic            acc_we, acc_re;
  logic [CAW-1:0]  acc_waddr, acc_raddr;
  logic [ACCW-1:0] acc_wdata, acc_rdata;

  // Divider ports.
  logic            div_start, div_busy, div_done;
  logic [SW-1:0]   div_num, div_quo;

  // Working values.
  logic [NPW-1:0]  np;
  logic [NCW-1:0]  nc;
  logic            in_acc;
  logic [CW-1:0]   vx, vy, vz;
  logic [CW-1:0]   px, py, pz, cx, cy, cz, dx, dy, dz;
  logic [DW-1:0]   dsum;
  logic [SW-1:0]   sx, sy, sz;
  logic [NPW-1:0]  cnt;
  logic [LW-1:0]   new_lab;
  logic [PRW-1:0]  lhs, rhs;

  kmc_ram #(.W(3 * CW), .D(POINTS)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .re(pt_re), .raddr(pt_raddr), .rdata(pt_rdata)
  );
  kmc_ram #(.W(LW), .D(POINTS)) u_lab_ram (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .re(lab_re), .raddr(lab_raddr), .rdata(lab_rdata)
  );
  kmc_ram #(.W(3 * CW), .D(CLUSTERS)) u_cen_ram (
    .clk(clk), .we(cen_we), .waddr(cen_waddr), .wdata(cen_wdata),
    .re(cen_re), .raddr(cen_raddr), .rdata(cen_rdata)
  );
  kmc_ram #(.W(ACCW), .D(CLUSTERS)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .re(acc_re), .raddr(acc_raddr), .rdata(acc_rdata)
  );
  kmc_div #(.NUMW(SW), .DENW(NPW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(cnt),
    .busy(div_busy), .done(div_done), .quo(div_quo)
  );

  // Effective counts, saturated to the storage sizes; a count of zero is taken as one.
  always_comb begin
    if (pc_r == 13'd0) begin
      np = NPW'(1);
    end else if (32'(pc_r) > 32'(POINTS)) begin
      np = NPW'(POINTS);
    end else begin
      np = NPW'(pc_r);
    end
    if (ncfg_r == 8'd0) begin
      nc = NCW'(1);
    end else if (32'(ncfg_r) > 32'(CLUSTERS)) begin
      nc = NCW'(CLUSTERS);
    end else begin
      nc = NCW'(ncfg_r);
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE) && (!ov_r || out_ch.ready);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Field views of the memory words.
  assign vx = CW'(in_ch.coord_x);
  assign vy = CW'(in_ch.coord_y);
  assign vz = CW'(in_ch.coord_z);
  assign {px, py, pz} = pt_rdata;
  assign {cx, cy, cz} = cen_rdata;
  assign {sx, sy, sz, cnt} = acc_rdata;
  assign dx = (px > cx) ? (px - cx) : (cx - px);
  assign dy = (py > cy) ? (py - cy) : (cy - py);
  assign dz = (pz > cz) ? (pz - cz) : (cz - pz);
  assign dsum = DW'(sqx_r) + DW'(sqy_r) + DW'(sqz_r);
  assign new_lab = LW'(best_r) + LW'(1);
  assign lhs = PRW'({chg_r, 16'b0});
  assign rhs = PRW'(thr_r) * PRW'(np);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    pj_nxt     = pj_r;
    kiss_nxt   = kiss_r;
    v1_nxt     = 1'b0;
    v2_nxt     = 1'b0;
    k1_nxt     = k1_r;
    k2_nxt     = k2_r;
    sqx_nxt    = sqx_r;
    sqy_nxt    = sqy_r;
    sqz_nxt    = sqz_r;
    best_nxt   = best_r;
    bestd_nxt  = bestd_r;
    chg_nxt    = chg_r;
    passes_nxt = passes_r;
    axis_nxt   = axis_r;
    qx_nxt     = qx_r;
    qy_nxt     = qy_r;
    qz_nxt     = qz_r;
    rdk_nxt    = rdk_r;
    ov_nxt     = ov_r && !out_ch.ready;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oz_nxt     = oz_r;
    olab_nxt   = olab_r;
    opass_nxt  = opass_r;
    oconv_nxt  = oconv_r;
    ost_nxt    = ost_r;
    pt_we = 1'b0; pt_re = 1'b0;
    pt_waddr = PW'(in_ch.item_index); pt_raddr = pj_r[PW-1:0];
    pt_wdata = {vx, vy, vz};
    lab_we = 1'b0; lab_re = 1'b0;
    lab_waddr = pj_r[PW-1:0]; lab_raddr = pj_r[PW-1:0];
    lab_wdata = new_lab;
    cen_we = 1'b0; cen_re = 1'b0;
    cen_waddr = kiss_r[CAW-1:0]; cen_raddr = kiss_r[CAW-1:0];
    cen_wdata = {qx_r, qy_r, qz_r};
    acc_we = 1'b0; acc_re = 1'b0;
    acc_waddr = best_r; acc_raddr = best_r;
    acc_wdata = {sx + SW'(px), sy + SW'(py), sz + SW'(pz), cnt + NPW'(1)};
    div_start = 1'b0;
    div_num   = sx;

    case (state_r)
      // Clearing pass over the label and centroid memories.
      ST_INIT: begin
        lab_waddr = clr_r[PW-1:0];
        lab_wdata = '0;
        cen_waddr = clr_r[CAW-1:0];
        cen_wdata = '0;
        lab_we    = 32'(clr_r) < 32'(POINTS);
        cen_we    = 32'(clr_r) < 32'(CLUSTERS);
        clr_nxt   = clr_r + CLRW'(1);
        if (32'(clr_r) == 32'(CLRN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      // Take one item; writes, ignored items, out-of-range reads and runs with a pass limit of zero answer at once.
      ST_IDLE: begin
        if (in_acc) begin
          ov_nxt    = 1'b0;
          ox_nxt    = '0;
          oy_nxt    = '0;
          oz_nxt    = '0;
          olab_nxt  = '0;
          opass_nxt = '0;
          oconv_nxt = 1'b0;
          ost_nxt   = 1'b0;
          cen_waddr = CAW'(in_ch.item_index);
          cen_raddr = CAW'(in_ch.item_index);
          lab_raddr = PW'(in_ch.item_index);
          cen_wdata = {vx, vy, vz};
          case (action_t'(in_ch.action))
            ACT_WR_POINT: begin
              ov_nxt = 1'b1;
              if (32'(in_ch.item_index) >= 32'(np)) begin
                ost_nxt = 1'b1;
              end else begin
                pt_we = 1'b1;
              end
            end
            ACT_WR_CENT: begin
              ov_nxt = 1'b1;
              if (32'(in_ch.item_index) >= 32'(nc)) begin
                ost_nxt = 1'b1;
              end else begin
                cen_we = 1'b1;
              end
            end
            ACT_RUN: begin
              if (mi_r == 8'd0) begin
                ov_nxt = 1'b1;
              end else begin
                passes_nxt = '0;
                kiss_nxt   = '0;
                state_nxt  = ST_CLR;
              end
            end
            ACT_RD_CENT: begin
              if (32'(in_ch.item_index) >= 32'(nc)) begin
                ov_nxt  = 1'b1;
                ost_nxt = 1'b1;
              end else begin
                cen_re    = 1'b1;
                rdk_nxt   = 1'b0;
                state_nxt = ST_RD;
              end
            end
            ACT_RD_LABEL: begin
              if (32'(in_ch.item_index) >= 32'(np)) begin
                ov_nxt  = 1'b1;
                ost_nxt = 1'b1;
              end else begin
                lab_re    = 1'b1;
                rdk_nxt   = 1'b1;
                state_nxt = ST_RD;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      // Read data is back; load the result.
      ST_RD: begin
        ov_nxt = 1'b1;
        if (rdk_r) begin
          olab_nxt = LBL_W'(lab_rdata);
        end else begin
          ox_nxt = CRD_W'(cx);
          oy_nxt = CRD_W'(cy);
          oz_nxt = CRD_W'(cz);
        end
        state_nxt = ST_IDLE;
      end
      // Zero the per-cluster sums at the start of a pass.
      ST_CLR: begin
        acc_we    = 1'b1;
        acc_waddr = kiss_r[CAW-1:0];
        acc_wdata = '0;
        kiss_nxt  = kiss_r + NCW'(1);
        if (kiss_r == nc - NCW'(1)) begin
          pj_nxt    = '0;
          chg_nxt   = '0;
          state_nxt = ST_PT;
        end
      end
      // Fetch the point and its old label.
      ST_PT: begin
        pt_re     = 1'b1;
        lab_re    = 1'b1;
        kiss_nxt  = '0;
        state_nxt = ST_SCAN;
      end
      // Stream centroids: read, square the differences, then sum and compare.
      ST_SCAN: begin
        if (kiss_r < nc) begin
          cen_re   = 1'b1;
          v1_nxt   = 1'b1;
          k1_nxt   = kiss_r[CAW-1:0];
          kiss_nxt = kiss_r + NCW'(1);
        end
        if (v1_r) begin
          sqx_nxt = {{CW{1'b0}}, dx} * {{CW{1'b0}}, dx};
          sqy_nxt = {{CW{1'b0}}, dy} * {{CW{1'b0}}, dy};
          sqz_nxt = {{CW{1'b0}}, dz} * {{CW{1'b0}}, dz};
          v2_nxt  = 1'b1;
          k2_nxt  = k1_r;
        end
        if (v2_r) begin
          if ((k2_r == '0) || (dsum < bestd_r)) begin
            best_nxt  = k2_r;
            bestd_nxt = dsum;
          end
        end
        if ((kiss_r == nc) && !v1_r && !v2_r) begin
          state_nxt = ST_ACC_RD;
        end
      end
      ST_ACC_RD: begin
        acc_re    = 1'b1;
        state_nxt = ST_ACC_WR;
      end
      // Accumulate the point and update its label.
      ST_ACC_WR: begin
        acc_we = 1'b1;
        if (lab_rdata != new_lab) begin
          lab_we  = 1'b1;
          chg_nxt = chg_r + NPW'(1);
        end
        pj_nxt = pj_r + NPW'(1);
        if (pj_r == np - NPW'(1)) begin
          state_nxt = ST_CHK;
        end else begin
          state_nxt = ST_PT;
        end
      end
      // Convergence test on the fraction of changed labels.
      ST_CHK: begin
        passes_nxt = passes_r + 8'd1;
        if (lhs < rhs) begin
          ov_nxt    = 1'b1;
          opass_nxt = passes_r + 8'd1;
          oconv_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          kiss_nxt  = '0;
          state_nxt = ST_U_RD;
        end
      end
      // Centroid update, one cluster at a time through the divider.
      ST_U_RD: begin
        acc_re    = 1'b1;
        acc_raddr = kiss_r[CAW-1:0];
        state_nxt = ST_U_CHK;
      end
      ST_U_CHK: begin
        axis_nxt = 2'd0;
        if (cnt == '0) begin
          qx_nxt    = '0;
          qy_nxt    = '0;
          qz_nxt    = '0;
          state_nxt = ST_U_WR;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_U_DIV;
        end
      end
      ST_U_DIV: begin
        div_num = (axis_r == 2'd0) ? sy : sz;
        if (div_done) begin
          case (axis_r)
            2'd0:    qx_nxt = CW'(div_quo);
            2'd1:    qy_nxt = CW'(div_quo);
            default: qz_nxt = CW'(div_quo);
          endcase
          if (axis_r == 2'd2) begin
            state_nxt = ST_U_WR;
          end else begin
            div_start = 1'b1;
            axis_nxt  = axis_r + 2'd1;
          end
        end
      end
      ST_U_WR: begin
        cen_we   = 1'b1;
        kiss_nxt = kiss_r + NCW'(1);
        if (kiss_r == nc - NCW'(1)) begin
          if (passes_r == mi_r) begin
            ov_nxt    = 1'b1;
            opass_nxt = passes_r;
            oconv_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            kiss_nxt  = '0;
            state_nxt = ST_CLR;
          end
        end else begin
          state_nxt = ST_U_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, registered outputs and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      clr_r    <= '0;
      ov_r     <= 1'b0;
      pj_r     <= '0;
      chg_r    <= '0;
      passes_r <= '0;
      kiss_r   <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      axis_r   <= '0;
      rdk_r    <= 1'b0;
      pc_r     <= RST_POINT_COUNT;
      ncfg_r   <= RST_CLUSTER_COUNT;
      mi_r     <= RST_MAX_ITER;
      thr_r    <= RST_THRESHOLD;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ov_r     <= ov_nxt;
      pj_r     <= pj_nxt;
      chg_r    <= chg_nxt;
      passes_r <= passes_nxt;
      kiss_r   <= kiss_nxt;
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
      axis_r   <= axis_nxt;
      rdk_r    <= rdk_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_POINT_COUNT:   pc_r   <= cfg_ch.data[12:0];
          CFG_CLUSTER_COUNT: ncfg_r <= cfg_ch.data[7:0];
          CFG_MAX_ITER:      mi_r   <= cfg_ch.data[7:0];
          CFG_THRESHOLD:     thr_r  <= cfg_ch.data[16:0];
          default: ;
        endcase
      end
    end
    k1_r    <= k1_nxt;
    k2_r    <= k2_nxt;
    sqx_r   <= sqx_nxt;
    sqy_r   <= sqy_nxt;
    sqz_r   <= sqz_nxt;
    best_r  <= best_nxt;
    bestd_r <= bestd_nxt;
    qx_r    <= qx_nxt;
    qy_r    <= qy_nxt;
    qz_r    <= qz_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oz_r    <= oz_nxt;
    olab_r  <= olab_nxt;
    opass_r <= opass_nxt;
    oconv_r <= oconv_nxt;
    ost_r   <= ost_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.out_x       = ox_r;
  assign out_ch.out_y       = oy_r;
  assign out_ch.out_z       = oz_r;
  assign out_ch.point_label = olab_r;
  assign out_ch.passes_done = opass_r;
  assign out_ch.converged   = oconv_r;
  assign out_ch.status      = ost_r;

  // The nearest centroid found by the scan is one that is in use.
  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC_WR |-> 32'(best_r) < 32'(nc))
    else $error("best cluster index beyond cluster count");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // A pass never counts more label changes than points visited.
  a_chg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHK |-> chg_r <= pj_r)
    else $error("change count exceeds visited points");

  // A finished run never reports more passes than the limit.
  a_pass_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) && (state_nxt == ST_IDLE) && ov_nxt |=> opass_r <= mi_r)
    else $error("pass count beyond iteration limit");
endmodule

// ----- rtl/core/kmc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module kmc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                         wdata,
  input  logic                                 re,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                         rdata
);
  logic [W-1:0] mem [D];

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/core/kmc_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module kmc_div #(
  parameter int NUMW = 22,
  parameter int DENW = 13
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            busy,
  output logic            done,
  output logic [NUMW-1:0] quo
);
  localparam int CNTW = $clog2(NUMW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [NUMW-1:0] quo_r, quo_nxt;
  logic [DENW-1:0] rem_r, rem_nxt;
  logic [DENW-1:0] den_r, den_nxt;
  logic [DENW:0]   trial;

  // One shift-and-subtract step per cycle, numerator bits enter MSB first.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, quo_r[NUMW-1]};
    if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DENW'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[NUMW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DENW-1:0];
        quo_nxt = {quo_r[NUMW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(NUMW);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ----- verif/kmc_checker.sv -----
// Checker for the k-means cluster engine: predicts every result and compares it.
`timescale 1ns / 100ps

module kmc_checker (
  input  logic clk,
  input  logic rst_n,
  kmc_in_if    in_ch,
  kmc_out_if   out_ch,
  kmc_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import kmc_pkg::*;

  localparam int NPTS = 4096;
  localparam int NCL  = 128;

  typedef struct packed {
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [CRD_W-1:0]  z;
    logic [LBL_W-1:0]  label;
    logic [PASS_W-1:0] passes;
    logic              conv;
    logic              status;
  } result_t;

  result_t expected_q[$];

  // Local copy of the engine state and registers.
  logic [12:0]      reg_points;
  logic [7:0]       reg_clusters;
  logic [7:0]       reg_iters;
  logic [16:0]      reg_thresh;
  logic [CRD_W-1:0] pt_x[NPTS], pt_y[NPTS], pt_z[NPTS];
  logic [LBL_W-1:0] labels[NPTS];
  logic [CRD_W-1:0] cen_x[NCL], cen_y[NCL], cen_z[NCL];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic int points_in_use();
    if (reg_points < 1) return 1;
    return (reg_points > NPTS) ? NPTS : int'(reg_points);
  endfunction

  function automatic int clusters_in_use();
    if (reg_clusters < 1) return 1;
    return (reg_clusters > NCL) ? NCL : int'(reg_clusters);
  endfunction

  function automatic longint sq(int a, int b);
    longint d;
    d = a - b;
    return d * d;
  endfunction

  // Lloyd passes until the changed-label fraction drops below the threshold or the pass limit is reached.
  task automatic lloyd_run(output logic [PASS_W-1:0] passes, output logic conv);
    int np, nc, best, changes;
    longint d, bestd;
    int sx[NCL], sy[NCL], sz[NCL], cnt[NCL];
    np = points_in_use();
    nc = clusters_in_use();
    passes = '0;
    conv = 1'b0;
    for (int pass = 0; pass < reg_iters; pass++) begin
      for (int k = 0; k < NCL; k++) begin
        sx[k] = 0; sy[k] = 0; sz[k] = 0; cnt[k] = 0;
      end
      changes = 0;
      for (int j = 0; j < np; j++) begin
        best = 0;
        bestd = sq(pt_x[j], cen_x[0]) + sq(pt_y[j], cen_y[0]) + sq(pt_z[j], cen_z[0]);
        for (int k = 1; k < nc; k++) begin
          d = sq(pt_x[j], cen_x[k]) + sq(pt_y[j], cen_y[k]) + sq(pt_z[j], cen_z[k]);
          if (d < bestd) begin
            bestd = d;
            best = k;
          end
        end
        if (labels[j] != LBL_W'(best + 1)) begin
          labels[j] = LBL_W'(best + 1);
          changes++;
        end
        sx[best] += pt_x[j];
        sy[best] += pt_y[j];
        sz[best] += pt_z[j];
        cnt[best]++;
      end
      passes = PASS_W'(pass + 1);
      if (longint'(changes) * 65536 < longint'(reg_thresh) * np) begin
        conv = 1'b1;
        return;
      end
      for (int k = 0; k < nc; k++) begin
        if (cnt[k] != 0) begin
          cen_x[k] = CRD_W'(sx[k] / cnt[k]);
          cen_y[k] = CRD_W'(sy[k] / cnt[k]);
          cen_z[k] = CRD_W'(sz[k] / cnt[k]);
        end else begin
          cen_x[k] = '0; cen_y[k] = '0; cen_z[k] = '0;
        end
      end
    end
  endtask

  // Apply one accepted item to the local state and return its result.
  task automatic predict_item(output result_t r);
    int idx;
    idx = in_ch.item_index;
    r = '0;
    case (in_ch.action)
      ACT_WR_POINT: begin
        if (idx >= points_in_use()) begin
          r.status = 1'b1;
        end else begin
          pt_x[idx] = in_ch.coord_x; pt_y[idx] = in_ch.coord_y; pt_z[idx] = in_ch.coord_z;
        end
      end
      ACT_WR_CENT: begin
        if (idx >= clusters_in_use()) begin
          r.status = 1'b1;
        end else begin
          cen_x[idx] = in_ch.coord_x; cen_y[idx] = in_ch.coord_y; cen_z[idx] = in_ch.coord_z;
        end
      end
      ACT_RUN: lloyd_run(r.passes, r.conv);
      ACT_RD_CENT: begin
        if (idx >= clusters_in_use()) begin
          r.status = 1'b1;
        end else begin
          r.x = cen_x[idx]; r.y = cen_y[idx]; r.z = cen_z[idx];
        end
      end
      ACT_RD_LABEL: begin
        if (idx >= points_in_use()) r.status = 1'b1;
        else r.label = labels[idx];
      end
      default: ;
    endcase
  endtask

  task automatic report(string field, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    result_t want, got;
    if (!rst_n) begin
      reg_points = RST_POINT_COUNT;
      reg_clusters = RST_CLUSTER_COUNT;
      reg_iters = RST_MAX_ITER;
      reg_thresh = RST_THRESHOLD;
      for (int j = 0; j < NPTS; j++) labels[j] = '0;
      for (int k = 0; k < NCL; k++) begin
        cen_x[k] = '0; cen_y[k] = '0; cen_z[k] = '0;
      end
      expected_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_POINT_COUNT:   reg_points = cfg_ch.data[12:0];
          CFG_CLUSTER_COUNT: reg_clusters = cfg_ch.data[7:0];
          CFG_MAX_ITER:      reg_iters = cfg_ch.data[7:0];
          CFG_THRESHOLD:     reg_thresh = cfg_ch.data[16:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.point_label,
                out_ch.passes_done, out_ch.converged, out_ch.status};
        if (expected_q.size() == 0) begin
          $display("%0t: result item with no expectation waiting", $realtime);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.x !== want.x) report("out_x", got.x, want.x);
          if (got.y !== want.y) report("out_y", got.y, want.y);
          if (got.z !== want.z) report("out_z", got.z, want.z);
          if (got.label !== want.label) report("point_label", got.label, want.label);
          if (got.passes !== want.passes) report("passes_done", got.passes, want.passes);
          if (got.conv !== want.conv) report("converged", got.conv, want.conv);
          if (got.status !== want.status) report("status", got.status, want.status);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_item(want);
        expected_q.push_back(want);
      end
    end
    pending = expected_q.size();
  end

endmodule

// ----- verif/kmeans_3d_cluster_engine_unit_tb.sv -----
// Testbench top of the k-means cluster engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module kmeans_3d_cluster_engine_unit_tb;
  import kmc_pkg::*;

  localparam int NPTS = 4096;
  localparam int RUN_BUDGET = 25000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  bit   no_idle;
  bit   written[NPTS];
  int   use_pts, use_cl, use_it;

  kmc_in_if  in_ch();
  kmc_out_if out_ch();
  kmc_cfg_if cfg_ch();

  kmeans_3d_cluster_engine_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  kmc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Result side: random stalls on ready.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk) out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk) out_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  task automatic send_item(logic [2:0] act, int idx, int x, int y, int z);
    int n;
    n = pick_gap();
    @(negedge clk);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.item_index <= IDX_W'(idx);
    in_ch.coord_x <= CRD_W'(x);
    in_ch.coord_y <= CRD_W'(y);
    in_ch.coord_z <= CRD_W'(z);
    do @(posedge clk); while (!in_ch.ready);
    if (act == ACT_WR_POINT && idx < use_pts) written[idx] = 1'b1;
  endtask

  // Hold the input side until every expected result has come back.
  task automatic drain();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  // Program all registers; the pass limit is cut so one run stays affordable.
  task automatic configure(int pc, int nc, int it, int th);
    int per_pass;
    use_pts = (pc % 8192 == 0) ? 1 : ((pc % 8192 > NPTS) ? NPTS : pc % 8192);
    use_cl = (nc % 256 == 0) ? 1 : ((nc % 256 > 128) ? 128 : nc % 256);
    per_pass = use_cl + use_pts * (use_cl + 6) + use_cl * 75 + 1;
    it = it % 256;
    if (it * per_pass > RUN_BUDGET) it = (RUN_BUDGET / per_pass < 1) ? 1 : RUN_BUDGET / per_pass;
    use_it = it;
    cfg_write(CFG_POINT_COUNT, pc);
    cfg_write(CFG_CLUSTER_COUNT, nc);
    cfg_write(CFG_MAX_ITER, it);
    cfg_write(CFG_THRESHOLD, th);
  endtask

  function automatic bit run_safe();
    if (use_it == 0) return 1'b1;
    for (int j = 0; j < use_pts; j++) if (!written[j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_idx(int lim);
    if ($urandom_range(0, 99) < 82) return $urandom_range(0, lim - 1);
    return $urandom_range(0, 4095);
  endfunction

  // One random item, weighted toward loads and reads, with a few runs.
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) drain();
    if (r < 33) begin
      send_item(ACT_WR_POINT, pick_idx(use_pts), $urandom, $urandom, $urandom);
    end else if (r < 48) begin
      send_item(ACT_WR_CENT, pick_idx(use_cl), $urandom, $urandom, $urandom);
    end else if (r < 66) begin
      send_item(ACT_RD_CENT, pick_idx(use_cl), $urandom, $urandom, $urandom);
    end else if (r < 85) begin
      send_item(ACT_RD_LABEL, pick_idx(use_pts), $urandom, $urandom, $urandom);
    end else if (r < 92 && run_safe()) begin
      send_item(ACT_RUN, $urandom, $urandom, $urandom, $urandom);
    end else begin
      send_item(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // Fill the points in use and the first centroids, then random items.
  task automatic phase_body(int count);
    for (int j = 0; j < use_pts && j < 64; j++)
      send_item(ACT_WR_POINT, j, $urandom, $urandom, $urandom);
    for (int k = 0; k < use_cl && k < 12; k++)
      send_item(ACT_WR_CENT, k, $urandom, $urandom, $urandom);
    repeat (count) random_item();
    drain();
  endtask

  initial begin
    int ths[4];
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WR_POINT;
    in_ch.item_index = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    no_idle = 1'b0;
    use_pts = NPTS;
    use_cl = 128;
    use_it = 30;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: extremes under the reset settings.
    send_item(ACT_RD_LABEL, 4095, 0, 0, 0);
    send_item(ACT_WR_POINT, 0, 0, 0, 0);
    send_item(ACT_WR_POINT, 4095, 1023, 1023, 1023);
    send_item(ACT_WR_POINT, 4094, 'h2AA, 'h155, 'h2AA);
    send_item(ACT_WR_CENT, 0, 1023, 1023, 1023);
    send_item(ACT_WR_CENT, 127, 'h155, 'h2AA, 'h155);
    send_item(ACT_WR_CENT, 128, 5, 5, 5);
    send_item(ACT_RD_CENT, 0, 0, 0, 0);
    send_item(ACT_RD_CENT, 127, 0, 0, 0);
    send_item(ACT_RD_CENT, 4095, 0, 0, 0);
    send_item(ACT_RD_CENT, 64, 0, 0, 0);
    send_item(3'd5, 4095, 1023, 1023, 1023);
    send_item(3'd6, 0, 0, 0, 0);
    send_item(3'd7, 1, 1, 1, 1);
    drain();

    // Directed: counts of zero saturate to one, long pass limit, zero threshold.
    configure(0, 0, 255, 0);
    send_item(ACT_WR_POINT, 0, 1023, 0, 512);
    send_item(ACT_WR_POINT, 1, 3, 3, 3);
    send_item(ACT_WR_CENT, 1, 3, 3, 3);
    send_item(ACT_WR_CENT, 0, 7, 9, 11);
    send_item(ACT_RUN, 0, 0, 0, 0);
    send_item(ACT_RD_LABEL, 0, 0, 0, 0);
    send_item(ACT_RD_LABEL, 1, 0, 0, 0);
    send_item(ACT_RD_CENT, 0, 0, 0, 0);
    drain();

    // Directed: counts above range saturate, no pass at all, widest threshold.
    configure(8191, 255, 0, 131071);
    send_item(ACT_RUN, 4095, 1023, 1023, 1023);
    send_item(ACT_RD_LABEL, 4095, 0, 0, 0);
    send_item(ACT_RD_CENT, 127, 0, 0, 0);
    drain();

    // Small point sets against the full and a small centroid table, then random settings.
    configure(16, 128, 3, 65536);
    phase_body(60);
    configure(20, 4, 255, 655);
    phase_body(60);
    ths = '{0, 655, 65536, 0};
    for (int ph = 0; ph < 10; ph++) begin
      no_idle = (ph % 4 == 1);
      ths[3] = $urandom_range(0, 131071);
      configure($urandom_range(1, 24),
                ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 128),
                ($urandom_range(0, 1) == 1) ? $urandom_range(1, 10) : $urandom_range(0, 255),
                ths[$urandom_range(0, 3)]);
      phase_body(55);
    end

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #200000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
